[rtl/tip_pkg.sv]
// ----------------------------------------------------------------------------
// tip_pkg
// shared types, codes and helpers for the table interpolator
// ----------------------------------------------------------------------------
package tip_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  // item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_QUAD_MODE   = 1'b1;

  localparam int CFG_W       = 7;
  localparam int COUNT_RESET = 6;

  // quotient saturation bound of the multiply-divide unit
  localparam logic [63:0] SAT_LIMIT = 64'h2000_0000_0000_0000;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_SHF
  } md_state_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic rem_nz;
  } md_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A0,
    S_A1,
    S_A2,
    S_SEG,
    S_SEGW,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_LIN,
    S_LINW,
    S_DCHK,
    S_MD,
    S_MDW,
    S_FIN
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_S1,
    OP_S2,
    OP_C2,
    OP_Q,
    OP_TERM
  } md_op_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

[rtl/tip_in_if.sv]
// ----------------------------------------------------------------------------
// tip_in_if
// input item channel: load or query items
// ----------------------------------------------------------------------------
interface tip_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [5:0]         point_index;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;

  modport source(output valid, command, point_index, sample_x, sample_y, input ready);
  modport sink(input valid, command, point_index, sample_x, sample_y, output ready);
endinterface

[rtl/tip_out_if.sv]
// ----------------------------------------------------------------------------
// tip_out_if
// result channel: interpolated value and error flag
// ----------------------------------------------------------------------------
interface tip_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic               error_flag;

  modport source(output valid, interp_value, error_flag, input ready);
  modport sink(input valid, interp_value, error_flag, output ready);
endinterface

[rtl/tip_ram.sv]
// ----------------------------------------------------------------------------
// tip_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tip_muldiv.sv]
// ----------------------------------------------------------------------------
// tip_muldiv
// bit-serial a*b/d: shift-add multiply then restoring divide or fixed shift
// ----------------------------------------------------------------------------
module tip_muldiv
  import tip_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               by_pow2,
  input  logic signed [63:0] op_a,
  input  logic signed [63:0] op_b,
  input  logic signed [63:0] op_d,
  output logic signed [63:0] quot,
  output md_status_t         status
);

  md_state_t    state_r, state_nxt;
  logic [6:0]   cnt_r;
  logic [63:0]  ua_r, ud_r, rem_r, q_r;
  logic [127:0] prod_r;
  logic         sat_r, neg_r, done_r, pow2_r;

  logic [64:0]  psum;
  logic [64:0]  rsh;
  logic         qb;
  logic [63:0]  qn, qmag;
  logic [127:0] shf;

  assign psum = {1'b0, prod_r[127:64]} + (prod_r[0] ? {1'b0, ua_r} : 65'd0);
  assign rsh  = {rem_r, prod_r[127]};
  assign qb   = rsh >= {1'b0, ud_r};
  assign qn   = {q_r[62:0], qb};
  // divisor of one fixed-point unit: the quotient is the product shifted down
  assign shf  = prod_r >> FRAC_BITS;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (start) state_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == 7'd63) state_nxt = pow2_r ? MD_SHF : MD_DIV;
      MD_DIV:  if (cnt_r == 7'd127) state_nxt = MD_IDLE;
      MD_SHF:  state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == MD_DIV) && (cnt_r == 7'd127)) || (state_r == MD_SHF);
      if (state_r == MD_IDLE || (state_r == MD_MUL && cnt_r == 7'd63)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          ua_r   <= mag64(op_a);
          ud_r   <= mag64(op_d);
          prod_r <= {64'd0, mag64(op_b)};
          neg_r  <= op_a[63] ^ op_b[63] ^ op_d[63];
          pow2_r <= by_pow2;
          rem_r  <= '0;
          q_r    <= '0;
          sat_r  <= 1'b0;
        end
      end
      MD_MUL: prod_r <= {psum, prod_r[63:1]};
      MD_DIV: begin
        prod_r <= {prod_r[126:0], 1'b0};
        rem_r  <= qb ? 64'(rsh - {1'b0, ud_r}) : rsh[63:0];
        if (!sat_r) begin
          q_r <= qn;
          if (qn > SAT_LIMIT) sat_r <= 1'b1;
        end
      end
      MD_SHF: begin
        rem_r <= '0;
        if (shf > {64'd0, SAT_LIMIT}) begin
          sat_r <= 1'b1;
        end else begin
          q_r <= shf[63:0];
        end
      end
      default: ;
    endcase
  end

  assign qmag          = sat_r ? SAT_LIMIT : q_r;
  assign quot          = neg_r ? -$signed(qmag) : $signed(qmag);
  assign status.done   = done_r;
  assign status.neg    = neg_r;
  assign status.rem_nz = rem_r != 64'd0;

endmodule

[rtl/table_interpolator.sv]
// ----------------------------------------------------------------------------
// table_interpolator
// point table with linear or newton quadratic interpolation of queries
// ----------------------------------------------------------------------------
// A load item writes one (x, y) point and gives no result.
// A query finds its segment, reads the neighbouring points from the x and y
// rams and runs every product and quotient through one bit-serial
// multiply-divide unit: 64 multiply steps and then either 128 divide steps
// or, for the rescale by one fixed-point unit, a single shift step. A linear
// query uses two full operations, a quadratic query six full operations and
// two rescales; the input is not ready while a query is in progress. Results
// sit in an output register so that the next item can be taken while a
// result waits for its transfer. Table entries read by a query must have
// been loaded first.
// ----------------------------------------------------------------------------
module table_interpolator
  import tip_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tip_in_if.sink           in_if,
  tip_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  // configuration
  logic [6:0] count_r;
  logic       quad_cfg_r;

  // sequencer state and working registers
  seq_state_t         state_r, state_nxt;
  md_op_t             op_r;
  logic               pass_r, quad_r, err_r;
  logic [6:0]         n_r, m_r, t_r;
  logic signed [31:0] xq_r, x0_r, xl_r, xa_r, ya_r, xb_r, yb_r, xc_r, yc_r;
  logic signed [63:0] v_r, s1_r, s2_r, c2_r, qv_r;

  // output register
  logic               out_valid_r, out_err_r;
  logic signed [31:0] out_val_r;

  // ram ports
  logic [31:0]   x_rd, y_rd;
  logic [6:0]    rd_idx;
  logic          ram_we;

  // multiply-divide unit
  logic               md_start, md_pow2;
  logic signed [63:0] md_a, md_b, md_d, md_q;
  md_status_t         md_st;

  logic [6:0]         n_in, seg_cnt, seg_hi;
  logic               in_acc, too_few, out_free;
  logic signed [63:0] xq64, den, dlin, d1, d2, d3, tq;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = state_r == S_IDLE;

  // points in use, capped at table size
  assign n_in    = (32'(count_r) > MAX_POINTS) ? 7'(MAX_POINTS) : count_r;
  assign too_few = quad_cfg_r ? (n_in < 7'd4) : (n_in < 7'd3);

  // the quadratic pass sees all points, the linear pass one fewer in quad mode
  assign seg_cnt = pass_r ? n_r : m_r;
  assign seg_hi  = pass_r ? n_r - 7'd2 : m_r - 7'd1;

  assign xq64 = 64'(xq_r);
  assign den  = 64'(xl_r) - 64'(x0_r);
  assign dlin = 64'(xb_r) - 64'(xa_r);
  assign d1   = 64'(xa_r) - 64'(xb_r);
  assign d2   = 64'(xb_r) - 64'(xc_r);
  assign d3   = 64'(xa_r) - 64'(xc_r);
  // ceiling: truncated quotient moves up only for a positive inexact result
  assign tq   = md_q + ((!md_st.neg && md_st.rem_nz) ? 64'sd1 : 64'sd0);

  // table rams
  assign ram_we = in_acc && (in_if.command == CMD_LOAD) && (32'(in_if.point_index) < MAX_POINTS);

  always_comb begin
    case (state_r)
      S_A1:    rd_idx = seg_cnt - 7'd1;
      S_R0:    rd_idx = t_r - 7'd1;
      S_R1:    rd_idx = t_r;
      S_R2:    rd_idx = t_r + 7'd1;
      default: rd_idx = 7'd0;
    endcase
  end

  tip_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_if.point_index)),
    .wdata (in_if.sample_x),
    .raddr (AW'(rd_idx)),
    .rdata (x_rd)
  );

  tip_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_if.point_index)),
    .wdata (in_if.sample_y),
    .raddr (AW'(rd_idx)),
    .rdata (y_rd)
  );

  // operand selection for the shared unit
  always_comb begin
    md_a    = 64'sd0;
    md_b    = 64'sd0;
    md_d    = ONE;
    md_pow2 = 1'b0;
    case (state_r)
      S_SEG: begin
        md_a = $signed({57'd0, seg_cnt - 7'd1});
        md_b = xq64 - 64'(x0_r);
        md_d = den;
      end
      S_LIN: begin
        md_a = xq64 - 64'(xa_r);
        md_b = 64'(yb_r) - 64'(ya_r);
        md_d = dlin;
      end
      S_MD: begin
        case (op_r)
          OP_S1: begin
            md_a = 64'(ya_r) - 64'(yb_r);
            md_b = ONE;
            md_d = d1;
          end
          OP_S2: begin
            md_a = 64'(yb_r) - 64'(yc_r);
            md_b = ONE;
            md_d = d2;
          end
          OP_C2: begin
            md_a = s1_r - s2_r;
            md_b = ONE;
            md_d = d3;
          end
          // rescale by one fixed-point unit is a shift in the unit
          OP_Q: begin
            md_a    = xq64 - 64'(xa_r);
            md_b    = xq64 - 64'(xb_r);
            md_pow2 = 1'b1;
          end
          OP_TERM: begin
            md_a    = qv_r;
            md_b    = c2_r;
            md_pow2 = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  tip_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (md_start),
    .by_pow2 (md_pow2),
    .op_a    (md_a),
    .op_b    (md_b),
    .op_d    (md_d),
    .quot    (md_q),
    .status  (md_st)
  );

  // sequencer: next state and unit start
  always_comb begin
    state_nxt = state_r;
    md_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_if.command == CMD_QUERY) begin
          state_nxt = too_few ? S_FIN : S_A0;
        end
      end
      S_A0: state_nxt = S_A1;
      S_A1: state_nxt = S_A2;
      S_A2: state_nxt = S_SEG;
      S_SEG: begin
        if (den == 64'sd0) begin
          state_nxt = S_FIN;
        end else begin
          md_start  = 1'b1;
          state_nxt = S_SEGW;
        end
      end
      S_SEGW: if (md_st.done) state_nxt = S_R0;
      S_R0:   state_nxt = S_R1;
      S_R1:   state_nxt = S_R2;
      S_R2:   state_nxt = pass_r ? S_R3 : S_LIN;
      S_R3:   state_nxt = S_DCHK;
      S_LIN: begin
        if (dlin == 64'sd0) begin
          state_nxt = S_FIN;
        end else begin
          md_start  = 1'b1;
          state_nxt = S_LINW;
        end
      end
      S_LINW: if (md_st.done) state_nxt = quad_r ? S_A0 : S_FIN;
      S_DCHK: begin
        if (d1 == 64'sd0 || d2 == 64'sd0 || d3 == 64'sd0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        md_start  = 1'b1;
        state_nxt = S_MDW;
      end
      S_MDW: begin
        if (md_st.done) state_nxt = (op_r == OP_TERM) ? S_FIN : S_MD;
      end
      S_FIN: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 7'(COUNT_RESET);
      quad_cfg_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: count_r    <= cfg_wdata;
          REG_QUAD_MODE:   quad_cfg_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        xq_r   <= in_if.sample_x;
        n_r    <= n_in;
        m_r    <= quad_cfg_r ? n_in - 7'd1 : n_in;
        quad_r <= quad_cfg_r;
        pass_r <= 1'b0;
        err_r  <= 1'b0;
        v_r    <= 64'sd0;
      end
      S_A1: x0_r <= x_rd;
      S_A2: xl_r <= x_rd;
      S_SEG: if (den == 64'sd0) err_r <= 1'b1;
      S_SEGW: begin
        if (md_st.done) begin
          if (tq < 64'sd1) begin
            t_r <= 7'd1;
          end else if (tq > $signed({57'd0, seg_hi})) begin
            t_r <= seg_hi;
          end else begin
            t_r <= tq[6:0];
          end
        end
      end
      S_R1: begin
        xa_r <= x_rd;
        ya_r <= y_rd;
      end
      S_R2: begin
        xb_r <= x_rd;
        yb_r <= y_rd;
      end
      S_R3: begin
        xc_r <= x_rd;
        yc_r <= y_rd;
      end
      S_LIN: if (dlin == 64'sd0) err_r <= 1'b1;
      S_LINW: begin
        if (md_st.done) begin
          v_r    <= 64'(ya_r) + md_q;
          pass_r <= 1'b1;
        end
      end
      S_DCHK: begin
        if (d1 == 64'sd0 || d2 == 64'sd0 || d3 == 64'sd0) err_r <= 1'b1;
        op_r <= OP_S1;
      end
      S_MDW: begin
        if (md_st.done) begin
          case (op_r)
            OP_S1: begin
              s1_r <= md_q;
              op_r <= OP_S2;
            end
            OP_S2: begin
              s2_r <= md_q;
              op_r <= OP_C2;
            end
            OP_C2: begin
              c2_r <= md_q;
              op_r <= OP_Q;
            end
            OP_Q: begin
              qv_r <= md_q;
              op_r <= OP_TERM;
            end
            OP_TERM: v_r <= v_r + md_q;
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_err_r <= err_r;
          if (err_r) begin
            out_val_r <= 32'sd0;
          end else if (v_r > 64'sd2147483647) begin
            out_val_r <= 32'h7fff_ffff;
          end else if (v_r < -64'sd2147483648) begin
            out_val_r <= 32'h8000_0000;
          end else begin
            out_val_r <= v_r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.interp_value = out_val_r;
  assign out_if.error_flag   = out_err_r;

  // an error result always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_val_r == 32'sd0))
    else $error("error result with nonzero value");

  // segment index stays inside the clamp range while points are read
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R0) |-> (t_r >= 7'd1 && t_r <= seg_hi))
    else $error("segment index out of range");

  // the unit only finishes while the sequencer waits for it
  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    md_st.done |-> (state_r == S_SEGW || state_r == S_LINW || state_r == S_MDW))
    else $error("unexpected multiply-divide completion");

endmodule
